/* rtl/abr_pkg.sv */
// Shared constants and types of the alternating-bit receiver.
`timescale 1ns / 1ps
`default_nettype none

package abr_pkg;

  // Default packet length in payload bytes and sequence number width.
  localparam int PAYLOAD_LEN = 20;
  localparam int SEQ_BITS    = 16;

  // Position-weighted byte sum of the ACK packet payload, the three characters of "ACK".
  localparam int ACK_PAYLOAD_SUM = 848;

  // Width of the checksum comparison: holds the sign-extended packet checksum
  // and the widest possible sum of the weighted payload, sequence and ack bit.
  localparam int TOT_W = 34;

  // Result kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  // Status of the checksum unit for the byte on the input.
  typedef struct packed {
    logic final_byte;  // the byte on the input closes the packet
    logic good;        // the packet total matches the carried checksum
  } csum_status_t;

endpackage

`default_nettype wire

/* rtl/abr_cell.sv */
// One byte cell of the payload chain; loads its neighbor's byte on a shift.
`timescale 1ns / 1ps
`default_nettype none

module abr_cell (
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire logic signed [7:0] din,
  output logic signed [7:0]      dout
);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

/* rtl/abr_csum.sv */
// Byte position counter and position-weighted checksum of the packet.
`timescale 1ns / 1ps
`default_nettype none

module abr_csum #(
  parameter int PAYLOAD_LEN = abr_pkg::PAYLOAD_LEN,
  parameter int SEQ_BITS    = abr_pkg::SEQ_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic signed [7:0]   payload_byte,
  input  wire logic [SEQ_BITS-1:0] seq_m,
  input  wire logic                ack_num,
  input  wire logic signed [31:0]  checksum,
  output abr_pkg::csum_status_t    status
);

  localparam int POS_W  = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
  // Largest magnitude of the weighted sum is 128 * LEN * (LEN + 1).
  localparam int WSUM_W = $clog2(128 * PAYLOAD_LEN * (PAYLOAD_LEN + 1) + 1) + 1;
  localparam int TOT_W  = abr_pkg::TOT_W;

  logic [POS_W-1:0]         pos;
  logic signed [WSUM_W-1:0] wsum;

  logic [WSUM_W-1:0]        wt_u;
  logic signed [WSUM_W-1:0] wt_s;
  logic signed [WSUM_W-1:0] byte_s;
  logic signed [WSUM_W-1:0] term;
  logic [TOT_W-1:0]         total;
  logic                     final_byte;

  always_comb begin
    wt_u       = (WSUM_W'(pos) + WSUM_W'(1)) << 1;
    wt_s       = $signed(wt_u);
    byte_s     = WSUM_W'(payload_byte);
    term       = byte_s * wt_s;
    final_byte = (pos == POS_W'(PAYLOAD_LEN - 1));
    total      = TOT_W'(wsum) + TOT_W'(term) + TOT_W'(seq_m) + TOT_W'(ack_num);
    status.final_byte = final_byte;
    status.good       = (total == TOT_W'(checksum));
  end

  // The sum and position restart after every final byte, good or corrupt.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      wsum <= '0;
    end else if (take) begin
      if (final_byte) begin
        pos  <= '0;
        wsum <= '0;
      end else begin
        pos  <= pos + POS_W'(1);
        wsum <= wsum + term;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/alternating_bit_receiver.sv */
// Top level of the alternating-bit receiver: byte chain, control and output register.
// A duplicate's ACK appears the cycle after its final byte is taken; a new packet's first
// byte follows through the state and then the output register, then one result per free
// cycle. Throughput: one payload byte per cycle while out_free; a new good packet stalls
// the input for the PAYLOAD_LEN + 1 output transactions that deliver the bytes and the
// ACK. Reset: synchronous, clears position, sum, expected sequence, ack bit and control.
`timescale 1ns / 1ps
`default_nettype none

module alternating_bit_receiver #(
  parameter int PAYLOAD_LEN = abr_pkg::PAYLOAD_LEN,
  parameter int SEQ_BITS    = abr_pkg::SEQ_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input channel: one payload byte per transaction.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [7:0]  payload_byte,
  input  wire logic [15:0]        seq_num,
  input  wire logic               ack_num,
  input  wire logic signed [31:0] checksum,
  // Output channel: delivered bytes and ACK packets.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    kind,
  output logic signed [7:0]       data_byte,
  output logic [15:0]             ack_seq,
  output logic                    ack_flag,
  output logic [16:0]             ack_checksum,
  output logic                    last
);

  localparam int CNT_W = $clog2(PAYLOAD_LEN + 1);

  // Control states: receiving bytes, or draining the chain to the output.
  localparam logic ST_RECV = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic [SEQ_BITS-1:0] expected_seq;
  logic                ack_bit;

  logic                 in_take;
  logic                 out_free;
  logic [31:0]          seq_wide;
  logic [SEQ_BITS-1:0]  seq_m;
  logic                 pkt_ok;
  logic                 dup;
  logic                 start_send;
  logic                 send_byte;
  logic                 load_ack;
  logic                 shift;
  logic signed [7:0]    chain_in;
  logic [SEQ_BITS-1:0]  prev_seq;
  logic [31:0]          prev_wide;
  logic [15:0]          prev_seq16;
  logic                 prev_flag;

  abr_pkg::csum_status_t status;

  // The chain of byte cells: new bytes enter at the tail and travel toward
  // cell 0, so after a full packet cell 0 holds the first byte. While the
  // packet is delivered, the head byte leaves and re-enters at the tail.
  logic signed [7:0] cell_q [PAYLOAD_LEN];

  genvar gi;
  generate
    for (gi = 0; gi < PAYLOAD_LEN; gi++) begin : g_cell
      if (gi == PAYLOAD_LEN - 1) begin : g_tail
        abr_cell u_cell (
          .clk  (clk),
          .shift(shift),
          .din  (chain_in),
          .dout (cell_q[gi])
        );
      end else begin : g_body
        abr_cell u_cell (
          .clk  (clk),
          .shift(shift),
          .din  (cell_q[gi+1]),
          .dout (cell_q[gi])
        );
      end
    end
  endgenerate

  // The sequence number is compared after masking to SEQ_BITS bits.
  assign seq_wide = 32'(seq_num);
  assign seq_m    = seq_wide[SEQ_BITS-1:0];

  abr_csum #(
    .PAYLOAD_LEN(PAYLOAD_LEN),
    .SEQ_BITS   (SEQ_BITS)
  ) u_csum (
    .clk         (clk),
    .rst         (rst),
    .take        (in_take),
    .payload_byte(payload_byte),
    .seq_m       (seq_m),
    .ack_num     (ack_num),
    .checksum    (checksum),
    .status      (status)
  );

  // The output register can be loaded when it is empty or being emptied.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_RECV) || !out_free;
  assign in_take  = in_valid && !in_stall;

  assign pkt_ok     = in_take && status.final_byte && status.good;
  assign dup        = (seq_m < expected_seq);
  assign start_send = pkt_ok && !dup;
  assign send_byte  = (state == ST_SEND) && out_free && (cnt != CNT_W'(PAYLOAD_LEN));
  // A duplicate is answered at once; a new packet gets its ACK after the bytes.
  assign load_ack   = (pkt_ok && dup)
                   || ((state == ST_SEND) && out_free && (cnt == CNT_W'(PAYLOAD_LEN)));

  assign shift    = in_take || send_byte;
  assign chain_in = in_take ? payload_byte : cell_q[0];

  // Every ACK names the packet last taken: expected_seq has already advanced
  // when a new packet's ACK goes out, and a duplicate finds it unchanged.
  assign prev_seq   = expected_seq - SEQ_BITS'(1);
  assign prev_wide  = 32'(prev_seq);
  assign prev_seq16 = prev_wide[15:0];
  assign prev_flag  = ~ack_bit;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_RECV: begin
        if (start_send) begin
          state_next = ST_SEND;
          cnt_next   = '0;
        end
      end
      ST_SEND: begin
        if (send_byte) begin
          cnt_next = cnt + CNT_W'(1);
        end else if (load_ack) begin
          state_next = ST_RECV;
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RECV;
      cnt          <= '0;
      expected_seq <= '0;
      ack_bit      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (start_send) begin
        expected_seq <= expected_seq + SEQ_BITS'(1);
        ack_bit      <= ~ack_bit;
      end
      if (send_byte || load_ack) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (send_byte) begin
      kind         <= abr_pkg::KIND_BYTE;
      data_byte    <= cell_q[0];
      ack_seq      <= '0;
      ack_flag     <= 1'b0;
      ack_checksum <= '0;
      last         <= 1'b0;
    end else if (load_ack) begin
      kind         <= abr_pkg::KIND_ACK;
      data_byte    <= '0;
      ack_seq      <= prev_seq16;
      ack_flag     <= prev_flag;
      ack_checksum <= 17'(abr_pkg::ACK_PAYLOAD_SUM) + 17'(prev_seq16) + 17'(prev_flag);
      last         <= 1'b1;
    end
  end

  // Only the ACK closes a run of results.
  a_last_is_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> kind == abr_pkg::KIND_ACK)
    else $error("last set on a delivered byte");

  // The ack bit and the expected sequence always advance together.
  a_ack_tracks_seq: assert property (@(posedge clk) disable iff (rst)
    ack_bit != $past(ack_bit) |-> expected_seq != $past(expected_seq))
    else $error("ack bit toggled without a sequence advance");

  // No input is taken while the chain is being drained.
  a_no_take_in_send: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEND |-> !in_take)
    else $error("input taken during delivery");

  // The delivery counter never runs past the packet length.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEND |-> cnt <= CNT_W'(PAYLOAD_LEN))
    else $error("delivery counter out of range");

  // An ACK carries a checksum consistent with its own header fields.
  a_ack_checksum: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == abr_pkg::KIND_ACK |->
      ack_checksum == 17'(abr_pkg::ACK_PAYLOAD_SUM) + 17'(ack_seq) + 17'(ack_flag))
    else $error("ACK checksum mismatch");

endmodule

`default_nettype wire
